/* hdl/assert_macros.svh */
// Assertion macros for the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, ignored while reset is held.
`define PFLD_ASSERT(lbl, clk_s, rstn_s, prop) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (prop)) \
    else $error("pfld checker: property failed");

// Clocked property that also holds across reset.
`define PFLD_ASSERT_NR(lbl, clk_s, prop) \
  lbl: assert property (@(posedge clk_s) (prop)) \
    else $error("pfld checker: property failed");

`endif

/* hdl/pfld_pkg.sv */
// Package: shared constants, codes, types and helpers of the page line drawing core.
`timescale 1ns / 1ps
`default_nettype none
package pfld_pkg;

  localparam int DEF_SCREEN_WIDTH  = 128;
  localparam int DEF_SCREEN_HEIGHT = 64;

  // Address arithmetic width: 5-bit page times up to 256 columns plus an 8-bit x.
  localparam int CALC_W = 14;
  // Signed working width for line clipping.
  localparam int SW     = 11;
  // Page index taken from the upper bits of an 8-bit row.
  localparam int PAGE_W = 5;

  localparam logic [2:0] OP_CLEAR = 3'd0;
  localparam logic [2:0] OP_PLOT  = 3'd1;
  localparam logic [2:0] OP_HLINE = 3'd2;
  localparam logic [2:0] OP_VLINE = 3'd3;
  localparam logic [2:0] OP_READ  = 3'd4;

  localparam logic [1:0] MODE_SET    = 2'd0;
  localparam logic [1:0] MODE_CLEAR  = 2'd1;
  localparam logic [1:0] MODE_INVERT = 2'd2;

  typedef struct packed {
    logic accept;
    logic setup_plot;
    logic setup_hl;
    logic setup_vl;
    logic advance_hl;
    logic advance_vl;
    logic vl_mask;
    logic mem_rd;
    logic mem_wr;
    logic clr_step;
    logic out_load;
  } pfld_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic hl_ok;
    logic vl_ok;
    logic hl_done;
    logic hl_paint;
    logic vl_last;
    logic out_free;
  } pfld_stat_t;

  // Apply a pixel mask to one byte; unused mode code acts as invert.
  function automatic logic [7:0] paint_byte(input logic [7:0] cur, input logic [7:0] msk,
                                            input logic [1:0] mode);
    logic [7:0] res;
    case (mode)
      MODE_SET:   res = cur | msk;
      MODE_CLEAR: res = cur & ~msk;
      default:    res = cur ^ msk;
    endcase
    return res;
  endfunction

endpackage
`default_nettype wire

/* hdl/pfld_ctrl.sv */
// Controller: command sequencing state machine for the page line drawing core.
`timescale 1ns / 1ps
`default_nettype none
module pfld_ctrl
  import pfld_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [2:0] in_op,
  input  wire pfld_stat_t stat,
  output pfld_cmd_t       cmd
);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_SETUP = 3'd2;
  localparam logic [2:0] ST_HL    = 3'd3;
  localparam logic [2:0] ST_VL    = 3'd4;
  localparam logic [2:0] ST_RD    = 3'd5;
  localparam logic [2:0] ST_WR    = 3'd6;
  localparam logic [2:0] ST_OUT   = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic [2:0] op_r, op_nxt;

  assign in_ready = (state_r == ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      op_r    <= OP_CLEAR;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    cmd       = '0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          op_nxt     = in_op;
          unique case (in_op) inside
            OP_CLEAR:                    state_nxt = ST_CLEAR;
            OP_PLOT, OP_HLINE, OP_VLINE: state_nxt = ST_SETUP;
            OP_READ:                     state_nxt = ST_RD;
            default:                     state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_SETUP: begin
        case (op_r)
          OP_PLOT: begin
            cmd.setup_plot = 1'b1;
            state_nxt      = ST_RD;
          end
          OP_HLINE: begin
            cmd.setup_hl = 1'b1;
            state_nxt    = stat.hl_ok ? ST_HL : ST_IDLE;
          end
          default: begin
            cmd.setup_vl = 1'b1;
            state_nxt    = stat.vl_ok ? ST_VL : ST_IDLE;
          end
        endcase
      end
      ST_HL: begin
        if (stat.hl_done) begin
          state_nxt = ST_IDLE;
        end else if (stat.hl_paint) begin
          state_nxt = ST_RD;
        end else begin
          cmd.advance_hl = 1'b1;
        end
      end
      ST_VL: begin
        cmd.vl_mask = 1'b1;
        state_nxt   = ST_RD;
      end
      ST_RD: begin
        cmd.mem_rd = 1'b1;
        state_nxt  = (op_r == OP_READ) ? ST_OUT : ST_WR;
      end
      ST_WR: begin
        cmd.mem_wr = 1'b1;
        case (op_r)
          OP_HLINE: begin
            cmd.advance_hl = 1'b1;
            state_nxt      = ST_HL;
          end
          OP_VLINE: begin
            cmd.advance_vl = 1'b1;
            state_nxt      = stat.vl_last ? ST_IDLE : ST_VL;
          end
          default: state_nxt = ST_IDLE;
        endcase
      end
      ST_OUT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

/* hdl/pfld_dp.sv */
// Datapath: frame store, clipping, address and mask registers, result register.
`timescale 1ns / 1ps
`default_nettype none
module pfld_dp
  import pfld_pkg::*;
#(
  parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire pfld_cmd_t         cmd,
  output pfld_stat_t             stat,
  input  wire logic signed [8:0] in_pos_x,
  input  wire logic signed [8:0] in_pos_y,
  input  wire logic signed [7:0] in_length,
  input  wire logic [7:0]        in_pattern,
  input  wire logic [1:0]        in_paint_mode,
  input  wire logic [9:0]        in_read_address,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [7:0]             out_read_data
);

  localparam int BUF_BYTES = SCREEN_WIDTH * SCREEN_HEIGHT / 8;
  localparam int MEM_AW    = $clog2(BUF_BYTES);
  localparam int CNT_W     = $clog2(SCREEN_WIDTH + 1);
  localparam logic [CALC_W-1:0] BUF_C     = CALC_W'(BUF_BYTES);
  localparam logic [CALC_W-1:0] WIDTH_C   = CALC_W'(SCREEN_WIDTH);
  localparam logic signed [SW-1:0] W_S    = SW'(SCREEN_WIDTH);
  localparam logic signed [SW-1:0] H_S    = SW'(SCREEN_HEIGHT);
  localparam logic [MEM_AW-1:0] CLR_LAST  = MEM_AW'(BUF_BYTES - 1);

  logic [7:0] mem [BUF_BYTES];

  // Latched command fields and working registers.
  logic signed [8:0] px_r, py_r;
  logic signed [7:0] len_r;
  logic [7:0]        pat_r, msk_r;
  logic [1:0]        mode_r;
  logic [CALC_W-1:0] addr_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [PAGE_W-1:0] page_r;
  logic [7:0]        ys_r, end_r;
  logic [7:0]        rd_data_r, out_data_r;
  logic              rd_ok_r;
  logic              out_valid_r;
  logic [MEM_AW-1:0] clr_r;

  function automatic logic [CALC_W-1:0] page_base(input logic [PAGE_W-1:0] pg);
    return CALC_W'(pg) * WIDTH_C;
  endfunction

  // Horizontal line clipping.
  logic signed [SW-1:0] px_s, py_s, len_s;
  logic signed [SW-1:0] hx_a, hw_a, hx_b, hw_b, hend, hw_c;
  logic                 hl_ok;
  // Vertical line clipping.
  logic signed [SW-1:0] ys, hb, vend_a, hc, vend;
  logic                 vl_ok;
  // Per-page vertical mask.
  logic [8:0] row0, row8;
  logic [2:0] lo7, hi7;
  logic [7:0] lo_mask, hi_mask, vmask;
  logic       in_range;
  logic [7:0] wr_data;

  always_comb begin
    px_s  = SW'(px_r);
    py_s  = SW'(py_r);
    len_s = SW'(len_r);

    hx_a  = len_r[7] ? (px_s + len_s) : px_s;
    hw_a  = len_r[7] ? -len_s : len_s;
    hx_b  = hx_a[SW-1] ? '0 : hx_a;
    hw_b  = hx_a[SW-1] ? (hw_a + hx_a) : hw_a;
    hend  = hx_b + hw_b;
    hw_c  = (hend > W_S) ? (W_S - hx_b) : hw_b;
    hl_ok = !py_r[8] && (py_s < H_S) && !hw_c[SW-1] && (hw_c != '0);

    ys     = py_r[8] ? '0 : py_s;
    hb     = py_r[8] ? (len_s + py_s) : len_s;
    vend_a = ys + hb;
    hc     = (vend_a > H_S) ? (H_S - ys) : hb;
    vend   = ys + hc;
    vl_ok  = !px_r[8] && (px_s < W_S) && !hc[SW-1] && (hc != '0);

    row0    = {1'b0, page_r, 3'b000};
    row8    = row0 + 9'd8;
    lo7     = ({1'b0, ys_r} > row0) ? ys_r[2:0] : 3'd0;
    hi7     = ({1'b0, end_r} < row8) ? end_r[2:0] : 3'd0;
    lo_mask = 8'hff << lo7;
    hi_mask = (hi7 != 3'd0) ? ((8'h01 << hi7) - 8'h01) : 8'hff;
    vmask   = lo_mask & hi_mask & pat_r;

    in_range = (addr_r < BUF_C);
    wr_data  = paint_byte(rd_data_r, msk_r, mode_r);
  end

  always_comb begin
    stat          = '0;
    stat.clr_last = (clr_r == CLR_LAST);
    stat.hl_ok    = hl_ok;
    stat.vl_ok    = vl_ok;
    stat.hl_done  = (cnt_r == '0);
    stat.hl_paint = pat_r[0];
    stat.vl_last  = (row8 >= {1'b0, end_r});
    stat.out_free = !out_valid_r || out_ready;
  end

  // Command and working registers.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      px_r   <= in_pos_x;
      py_r   <= in_pos_y;
      len_r  <= in_length;
      pat_r  <= in_pattern;
      mode_r <= in_paint_mode;
      addr_r <= CALC_W'(in_read_address);
    end else if (cmd.setup_plot) begin
      addr_r <= page_base(py_r[7:3]) + CALC_W'(px_r[7:0]);
      msk_r  <= 8'h01 << py_r[2:0];
    end else if (cmd.setup_hl) begin
      addr_r <= page_base(py_r[7:3]) + CALC_W'(hx_b[7:0]);
      msk_r  <= 8'h01 << py_r[2:0];
      cnt_r  <= hw_c[CNT_W-1:0];
    end else if (cmd.setup_vl) begin
      addr_r <= page_base(ys[7:3]) + CALC_W'(px_r[7:0]);
      page_r <= ys[7:3];
      ys_r   <= ys[7:0];
      end_r  <= vend[7:0];
      mode_r <= MODE_INVERT;
    end else if (cmd.advance_hl) begin
      pat_r  <= {pat_r[0], pat_r[7:1]};
      addr_r <= addr_r + CALC_W'(1);
      cnt_r  <= cnt_r - CNT_W'(1);
    end else if (cmd.advance_vl) begin
      page_r <= page_r + PAGE_W'(1);
      addr_r <= addr_r + WIDTH_C;
    end else if (cmd.vl_mask) begin
      msk_r  <= vmask;
    end
  end

  // Frame store: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (cmd.clr_step) begin
      mem[clr_r] <= 8'h00;
    end else if (cmd.mem_wr && in_range) begin
      mem[addr_r[MEM_AW-1:0]] <= wr_data;
    end
    if (cmd.mem_rd) begin
      rd_ok_r <= in_range;
      if (in_range) rd_data_r <= mem[addr_r[MEM_AW-1:0]];
    end
  end

  // Clear sweep counter, wraps to zero after the last byte.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
    end else if (cmd.clr_step) begin
      clr_r <= stat.clr_last ? '0 : clr_r + MEM_AW'(1);
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) out_data_r <= rd_ok_r ? rd_data_r : 8'h00;
  end

  assign out_valid     = out_valid_r;
  assign out_read_data = out_data_r;

endmodule
`default_nettype wire

/* hdl/page_framebuffer_line_draw_core.sv */
// Top level of the monochrome page framebuffer drawing core.
`timescale 1ns / 1ps
`default_nettype none
// Drawing engine over a monochrome buffer of SCREEN_WIDTH*SCREEN_HEIGHT/8 bytes, one byte per
// column per 8-row page (bit n = row n of the page). One command per input transaction:
// clear, plot, stippled horizontal line, masked vertical line (always inverts), or byte read.
// Only a read produces an output transaction. Commands run one at a time; in_ready is high
// only while the engine is idle. Steps from acceptance to the next in_ready:
//   clear       sweeps all SCREEN_WIDTH*SCREEN_HEIGHT/8 bytes, one byte a cycle
//   plot        setup, read, write back
//   horiz line  setup, then per column a skip if its stipple bit is 0, else read and write back
//   vert line   setup, then per page touched a mask step, read and write back
//   read        read, then output load, held off while the previous result still waits
//   other ops   accepted and dropped; the engine stays idle
// Each painted byte is a read-modify-write over the frame store, which sets the per-byte
// cost. After reset the same clearing sweep runs with in_ready low. The read result sits in
// an output register, so the next command is taken while it waits for out_ready.
module page_framebuffer_line_draw_core
  import pfld_pkg::*;
#(
  parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [2:0]        in_op,
  input  wire logic signed [8:0] in_pos_x,
  input  wire logic signed [8:0] in_pos_y,
  input  wire logic signed [7:0] in_length,
  input  wire logic [7:0]        in_pattern,
  input  wire logic [1:0]        in_paint_mode,
  input  wire logic [9:0]        in_read_address,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [7:0]             out_read_data
);

  pfld_cmd_t  cmd;
  pfld_stat_t stat;

  // Sequencer: decodes the op and steps through clear sweep, setup, per-byte read-modify-write and result load.
  pfld_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_op    (in_op),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Frame store, clipping math, address/mask registers and the result register.
  pfld_dp #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_pos_x        (in_pos_x),
    .in_pos_y        (in_pos_y),
    .in_length       (in_length),
    .in_pattern      (in_pattern),
    .in_paint_mode   (in_paint_mode),
    .in_read_address (in_read_address),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_read_data   (out_read_data)
  );

endmodule
`default_nettype wire

/* hdl/pfld_checker.sv */
// Port-level checker for the page line drawing core, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module pfld_checker
  import pfld_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic [2:0] in_op,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_read_data
);

  logic acc;
  assign acc = in_valid && in_ready;

  `PFLD_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_read_data))
  `PFLD_ASSERT(a_no_spurious, clk, rst_n, acc && (in_op != OP_READ) && !out_valid |=> !out_valid)
  `PFLD_ASSERT(a_read_latency, clk, rst_n, acc && (in_op == OP_READ) && !out_valid |-> ##3 out_valid)
  `PFLD_ASSERT_NR(a_reset_sweep, clk, !rst_n |=> !in_ready)

endmodule

bind page_framebuffer_line_draw_core pfld_checker u_pfld_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .in_op         (in_op),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_read_data (out_read_data)
);
`default_nettype wire
